### rtl/four_step_wrapped_phase_core_macros.svh
// Assertion macros for the four-step wrapped phase core.
`ifndef FOUR_STEP_WRAPPED_PHASE_CORE_MACROS_SVH
`define FOUR_STEP_WRAPPED_PHASE_CORE_MACROS_SVH

// Concurrent implication, checked at the rising edge outside reset.
`define FSWP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Concurrent implication, consequent checked in the cycle after the antecedent.
`define FSWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fswp_pkg.sv
// Package: shared constants, types and arctangent table functions.
package fswp_pkg;

  localparam int unsigned PhaseFracBits = 14;
  localparam int unsigned CordicSteps   = 16;
  localparam int unsigned SampleW       = 8;
  localparam int unsigned DiffW         = SampleW + 1;
  localparam int unsigned PhaseW        = 16;
  localparam int unsigned AngBits       = 60;
  localparam int unsigned VecShift      = 40;
  localparam int unsigned VecW          = 53;
  localparam int unsigned AngW          = 64;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_PI,
    KIND_ZERO,
    KIND_UNDEF
  } kind_e;

  typedef struct packed {
    logic [SampleW-1:0]       x0;
    logic signed [DiffW-1:0]  y0;
    kind_e                    kind;
  } work_t;

  // unsigned quotient by shift and subtract, elaboration-time only
  function automatic longint unsigned div_u64(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/5) when sel is 0, atan(1/239) when sel is 1, in 2^-60 rad
  function automatic longint atan_inv(input bit sel);
    longint unsigned n;
    longint unsigned n2;
    longint unsigned p;
    longint unsigned term;
    longint unsigned k;
    longint sum;
    n = sel ? 64'd239 : 64'd5;
    n2 = n * n;
    p = div_u64(64'd1 << AngBits, n);
    sum = longint'(p);
    k = 1;
    while (p != 0) begin
      p = div_u64(p, n2);
      term = div_u64(p, 2 * k + 1);
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
      k = k + 1;
    end
    return sum;
  endfunction

  // atan(2^-i) in 2^-60 rad
  function automatic longint atan_pow2(input int unsigned i);
    longint unsigned p;
    longint unsigned term;
    longint unsigned k;
    int unsigned sh;
    longint sum;
    if (i == 0) return 4 * atan_inv(1'b0) - atan_inv(1'b1);
    if (i >= AngBits) return 0;
    p = (64'd1 << AngBits) >> i;
    sh = 2 * i;
    sum = longint'(p);
    k = 1;
    while (p != 0) begin
      p = (sh < 64) ? (p >> sh) : 64'd0;
      term = div_u64(p, 2 * k + 1);
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
      k = k + 1;
    end
    return sum;
  endfunction

  function automatic longint half_pi();
    return 2 * atan_pow2(0);
  endfunction

endpackage

### rtl/fswp_intf.sv
// Handshake interfaces for sample words and phase words.
interface fswp_in_if;
  logic                        valid;
  logic                        ready;
  logic [fswp_pkg::SampleW-1:0] sample_one;
  logic [fswp_pkg::SampleW-1:0] sample_two;
  logic [fswp_pkg::SampleW-1:0] sample_three;
  logic [fswp_pkg::SampleW-1:0] sample_four;
  modport source(output valid, sample_one, sample_two, sample_three, sample_four,
                 input ready);
  modport sink(input valid, sample_one, sample_two, sample_three, sample_four,
               output ready);
endinterface

interface fswp_out_if;
  logic                        valid;
  logic                        ready;
  logic [fswp_pkg::PhaseW-1:0] wrapped_phase;
  logic                        phase_undefined;
  modport source(output valid, wrapped_phase, phase_undefined, input ready);
  modport sink(input valid, wrapped_phase, phase_undefined, output ready);
endinterface

### rtl/fswp_front.sv
// Front end: forms numerator and denominator and classifies each word.
module fswp_front (
  fswp_in_if.sink             in_i,
  input  logic                push_ready_i,
  output logic                push_valid_o,
  output fswp_pkg::work_t     push_work_o
);

  logic signed [fswp_pkg::DiffW-1:0] num;
  logic signed [fswp_pkg::DiffW-1:0] den;
  logic signed [fswp_pkg::DiffW-1:0] den_abs;

  assign num = $signed({1'b0, in_i.sample_four}) - $signed({1'b0, in_i.sample_two});
  assign den = $signed({1'b0, in_i.sample_one}) - $signed({1'b0, in_i.sample_three});
  assign den_abs = den[fswp_pkg::DiffW-1] ? -den : den;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_work_o.x0 = den_abs[fswp_pkg::SampleW-1:0];
    push_work_o.y0 = den[fswp_pkg::DiffW-1] ? -num : num;
    if (den != '0) begin
      push_work_o.kind = fswp_pkg::KIND_NORMAL;
    end else if (num == '0) begin
      push_work_o.kind = fswp_pkg::KIND_UNDEF;
    end else if (num[fswp_pkg::DiffW-1]) begin
      push_work_o.kind = fswp_pkg::KIND_ZERO;
    end else begin
      push_work_o.kind = fswp_pkg::KIND_PI;
    end
  end

endmodule

### rtl/fswp_queue.sv
// Short queue between front end and CORDIC back end.
module fswp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fswp_pkg::work_t push_work_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fswp_pkg::work_t pop_work_o
);

  localparam int unsigned PtrW = $clog2(fswp_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(fswp_pkg::QueueDepth + 1);

  fswp_pkg::work_t mem_q [fswp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(fswp_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_work_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(fswp_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(fswp_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_work_i;
  end

endmodule

### rtl/fswp_back.sv
// Back end: pipelined CORDIC vectoring, clamp, rounding and output register.
module fswp_back #(
  parameter int unsigned PHASE_FRAC_BITS = fswp_pkg::PhaseFracBits,
  parameter int unsigned CORDIC_STEPS    = fswp_pkg::CordicSteps
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            work_valid_i,
  output logic            work_ready_o,
  input  fswp_pkg::work_t work_i,
  fswp_out_if.source      out_o
);

  localparam int unsigned VecW = fswp_pkg::VecW;
  localparam int unsigned AngW = fswp_pkg::AngW;
  localparam int unsigned Sh   = fswp_pkg::AngBits - PHASE_FRAC_BITS;
  localparam longint HalfPi    = fswp_pkg::half_pi();
  localparam logic [AngW-1:0] Rnd = AngW'(64'd1) << (Sh - 1);
  localparam logic [AngW-1:0] PiSum = AngW'(2 * HalfPi) + Rnd;
  localparam logic [AngW-1:0] PiFull = PiSum >> Sh;
  localparam logic [fswp_pkg::PhaseW-1:0] PiCode = PiFull[fswp_pkg::PhaseW-1:0];

  logic signed [VecW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [VecW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [AngW-1:0] z_q [CORDIC_STEPS+1];
  fswp_pkg::kind_e        kind_q [CORDIC_STEPS+1];
  logic                   vld_q [CORDIC_STEPS+1];

  logic en;
  logic out_valid_q;
  logic [fswp_pkg::PhaseW-1:0] phase_q, phase_d;
  logic undef_q;

  assign en           = !out_valid_q || out_o.ready;
  assign work_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= work_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= {{(VecW - fswp_pkg::SampleW - fswp_pkg::VecShift){1'b0}}, work_i.x0,
                 {fswp_pkg::VecShift{1'b0}}};
      y_q[0] <= {{(VecW - fswp_pkg::DiffW - fswp_pkg::VecShift){work_i.y0[fswp_pkg::DiffW-1]}},
                 work_i.y0, {fswp_pkg::VecShift{1'b0}}};
      z_q[0] <= '0;
      kind_q[0] <= work_i.kind;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    localparam logic signed [AngW-1:0] Ta = AngW'(fswp_pkg::atan_pow2(s));
    logic signed [VecW-1:0] xs, ys;
    assign xs = x_q[s] >>> s;
    assign ys = y_q[s] >>> s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        kind_q[s+1] <= kind_q[s];
        if (!y_q[s][VecW-1]) begin
          x_q[s+1] <= x_q[s] + ys;
          y_q[s+1] <= y_q[s] - xs;
          z_q[s+1] <= z_q[s] + Ta;
        end else begin
          x_q[s+1] <= x_q[s] - ys;
          y_q[s+1] <= y_q[s] + xs;
          z_q[s+1] <= z_q[s] - Ta;
        end
      end
    end
  end

  logic signed [AngW-1:0] z_cl;
  logic [AngW-1:0] sum, rounded;

  always_comb begin
    z_cl = z_q[CORDIC_STEPS];
    if (z_cl > AngW'(HalfPi)) z_cl = AngW'(HalfPi);
    if (z_cl < -AngW'(HalfPi)) z_cl = -AngW'(HalfPi);
    sum     = AngW'(HalfPi) + z_cl;
    rounded = (sum + Rnd) >> Sh;
    case (kind_q[CORDIC_STEPS])
      fswp_pkg::KIND_NORMAL: phase_d = rounded[fswp_pkg::PhaseW-1:0];
      fswp_pkg::KIND_PI:     phase_d = PiCode;
      default:               phase_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_q <= phase_d;
      undef_q <= (kind_q[CORDIC_STEPS] == fswp_pkg::KIND_UNDEF);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.wrapped_phase   = phase_q;
  assign out_o.phase_undefined = undef_q;

endmodule

### rtl/four_step_wrapped_phase_core.sv
// Top level: four-step wrapped phase core, front end, queue and CORDIC back end.
// Takes one sample word per clock and returns one phase word per clock unless
// the output word is held, the phase pi/2 + atan((s4 - s2) / (s1 - s3)) in
// unsigned radians with PHASE_FRAC_BITS fraction bits. An accepted word passes
// the two-entry queue, the input register, the CORDIC pipeline and the output
// register; the CORDIC pipeline has one stage per iteration and stalls as a
// whole while the output word is held. A zero denominator gives pi or 0 by the
// numerator's sign; both zero give 0 with phase_undefined set.
`include "four_step_wrapped_phase_core_macros.svh"

module four_step_wrapped_phase_core #(
  parameter int unsigned PHASE_FRAC_BITS = fswp_pkg::PhaseFracBits,
  parameter int unsigned CORDIC_STEPS    = fswp_pkg::CordicSteps
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fswp_in_if.sink     in_i,
  fswp_out_if.source  out_o
);

  localparam int unsigned Sh = fswp_pkg::AngBits - PHASE_FRAC_BITS;
  localparam logic [fswp_pkg::AngW-1:0] PiFull =
    (fswp_pkg::AngW'(2 * fswp_pkg::half_pi()) + (fswp_pkg::AngW'(64'd1) << (Sh - 1))) >> Sh;
  localparam logic [fswp_pkg::PhaseW-1:0] PiMax = PiFull[fswp_pkg::PhaseW-1:0];

  logic            push_valid, push_ready, pop_valid, pop_ready;
  fswp_pkg::work_t push_work, pop_work;

  fswp_front u_front (
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_work_o  (push_work)
  );

  fswp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_work_i  (push_work),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_work_o   (pop_work)
  );

  fswp_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (pop_valid),
    .work_ready_o (pop_ready),
    .work_i       (pop_work),
    .out_o        (out_o)
  );

  `FSWP_ASSERT_IMPL(a_undef_zero, clk_i, rst_ni, out_o.valid && out_o.phase_undefined, out_o.wrapped_phase == '0, "undefined phase word carries nonzero phase")
  `FSWP_ASSERT_IMPL(a_phase_range, clk_i, rst_ni, out_o.valid, out_o.wrapped_phase <= PiMax, "phase above pi")
  `FSWP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, $stable(out_o.wrapped_phase) && $stable(out_o.phase_undefined), "stalled phase word changed")

endmodule
